// ===== hw/rtl/bee_pkg.sv =====
// ----------------------------------------------------------------------------
// bee_pkg
// Shared types and constants of the boolean expression evaluator: parser
// modes, operator and status codes, character codes and the stack frame.
// ----------------------------------------------------------------------------
package bee_pkg;

    // default sizes
    localparam int unsigned          NEST_DEPTH_DEF   = 16;
    localparam longint unsigned      MAX_POSITION_DEF = 64'd65535;

    // field widths
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ERRPOS_W = 16;

    // parser mode
    typedef enum logic [1:0] {
        MODE_TERM = 2'd0,
        MODE_OPER = 2'd1,
        MODE_SKIP = 2'd2
    } mode_t;

    // pending binary operator
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_AND  = 2'd1,
        OP_OR   = 2'd2
    } op_t;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_SYNTAX = 2'd1,
        STATUS_LIMIT  = 2'd2
    } status_t;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_AND    = 8'h26;  // &
    localparam logic [CHAR_W-1:0] CH_OR     = 8'h7C;  // |
    localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;  // (
    localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;  // )
    localparam logic [CHAR_W-1:0] CH_NOT    = 8'h21;  // !
    localparam logic [CHAR_W-1:0] CH_TRUE   = 8'h79;  // y
    localparam logic [CHAR_W-1:0] CH_FALSE  = 8'h6E;  // n

    // saved context of an enclosing parenthesis level
    typedef struct packed {
        logic negate;
        op_t  op;
        logic left;
    } frame_t;

endpackage

// ===== hw/rtl/boolean_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// boolean_expression_evaluator
// Streaming evaluator of y/n expressions with !, &, | and parentheses.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle and keeps taking characters while a
// result waits at the output, as long as out_ready is high when out_valid is.
// Binary operators apply left to right with no precedence. A result (status,
// truth_value, error_position) appears in the cycle after the character that
// ends the top-level expression or that raises an error; characters after it
// are dropped up to the zero byte, which starts a new expression. Nesting
// frames live in a single-port-write memory with a registered read;
// the innermost frame is held in a register and the one below it is read
// ahead every cycle, with a write-to-read bypass, so that a ')' needs no
// wait. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module boolean_expression_evaluator #(
    parameter int unsigned     NEST_DEPTH   = bee_pkg::NEST_DEPTH_DEF,
    parameter longint unsigned MAX_POSITION = bee_pkg::MAX_POSITION_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bee_pkg::CHAR_W-1:0]    char_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bee_pkg::STATUS_W-1:0]  status,
    output logic                          truth_value,
    output logic [bee_pkg::ERRPOS_W-1:0]  error_position
);

    localparam int unsigned NW = $clog2(NEST_DEPTH + 1);
    localparam int unsigned AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int unsigned PW = $clog2(MAX_POSITION + 64'd2);

    // parser state
    bee_pkg::mode_t     mode_reg, mode_next;
    logic [NW-1:0]      nest_reg, nest_next;
    logic               left_reg, left_next;
    bee_pkg::op_t       op_reg, op_next;
    logic               neg_reg, neg_next;
    logic [PW-1:0]      pos_reg, pos_next;
    bee_pkg::frame_t    top_reg, top_next;

    // frame memory and read-ahead of the frame below the top
    bee_pkg::frame_t    frame_mem [NEST_DEPTH];
    bee_pkg::frame_t    mem_q_reg;
    logic               fwd_reg;
    bee_pkg::frame_t    fwd_data_reg;
    bee_pkg::frame_t    below;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    // output register
    logic                          out_valid_reg;
    logic [bee_pkg::STATUS_W-1:0]  status_reg;
    logic                          truth_reg;
    logic [bee_pkg::ERRPOS_W-1:0]  errpos_reg;

    // decode
    logic               accept;
    logic               active;
    logic               len_ovf;
    logic               nest_full;
    logic               is_lit;
    logic               lit_val;
    logic               is_opchar;
    logic               emit;
    logic               restart;
    bee_pkg::status_t   emit_status;
    logic [63:0]        pos64;
    logic [bee_pkg::ERRPOS_W-1:0] pos_sat;
    logic               fin_left;
    logic               fin_val;
    bee_pkg::op_t       fin_op;
    logic               fin_neg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign active    = (mode_reg == bee_pkg::MODE_TERM) || (mode_reg == bee_pkg::MODE_OPER);
    assign pos64     = 64'(pos_reg);
    assign len_ovf   = pos64 > MAX_POSITION;
    assign pos_sat   = (pos64 > 64'hFFFF) ? {bee_pkg::ERRPOS_W{1'b1}}
                                          : pos64[bee_pkg::ERRPOS_W-1:0];
    assign nest_full = 32'(nest_reg) >= NEST_DEPTH;
    assign is_lit    = (char_code == bee_pkg::CH_TRUE) || (char_code == bee_pkg::CH_FALSE);
    assign lit_val   = (char_code == bee_pkg::CH_TRUE);
    assign is_opchar = (char_code == bee_pkg::CH_AND) || (char_code == bee_pkg::CH_OR);

    assign below = fwd_reg ? fwd_data_reg : mem_q_reg;

    // result decision for the current character
    always_comb
    begin
        emit        = 1'b0;
        emit_status = bee_pkg::STATUS_OK;
        if (active)
        begin
            if (len_ovf)
            begin
                emit        = 1'b1;
                emit_status = bee_pkg::STATUS_LIMIT;
            end
            else if (mode_reg == bee_pkg::MODE_TERM)
            begin
                if (char_code == bee_pkg::CH_OPEN)
                begin
                    emit        = nest_full;
                    emit_status = bee_pkg::STATUS_LIMIT;
                end
                else if (!is_lit && char_code != bee_pkg::CH_NOT)
                begin
                    emit        = 1'b1;
                    emit_status = bee_pkg::STATUS_SYNTAX;
                end
            end
            else if (!is_opchar)
            begin
                if (nest_reg == '0)
                begin
                    emit        = 1'b1;
                    emit_status = bee_pkg::STATUS_OK;
                end
                else if (char_code != bee_pkg::CH_CLOSE)
                begin
                    emit        = 1'b1;
                    emit_status = bee_pkg::STATUS_SYNTAX;
                end
            end
        end
    end

    assign restart = (char_code == bee_pkg::CH_NUL) && (!active || emit);

    // next parser mode
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (restart)
                mode_next = bee_pkg::MODE_TERM;
            else if (emit)
                mode_next = bee_pkg::MODE_SKIP;
            else
            begin
                unique case (mode_reg)
                    bee_pkg::MODE_TERM:
                        if (is_lit)
                            mode_next = bee_pkg::MODE_OPER;
                    bee_pkg::MODE_OPER:
                        if (is_opchar)
                            mode_next = bee_pkg::MODE_TERM;
                    default:
                        mode_next = bee_pkg::MODE_SKIP;
                endcase
            end
        end
    end

    // term completion: parenthesis close restores the saved context first
    always_comb
    begin
        if (mode_reg == bee_pkg::MODE_OPER)
        begin
            fin_left = top_reg.left;
            fin_op   = top_reg.op;
            fin_neg  = top_reg.negate;
            fin_val  = left_reg;
        end
        else
        begin
            fin_left = left_reg;
            fin_op   = op_reg;
            fin_neg  = neg_reg;
            fin_val  = lit_val;
        end
    end

    // datapath and stack control
    always_comb
    begin
        nest_next = nest_reg;
        left_next = left_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        pos_next  = pos_reg;
        top_next  = top_reg;
        wr_en     = 1'b0;
        wr_addr   = AW'(nest_reg - NW'(1));
        if (accept)
        begin
            if (restart)
            begin
                nest_next = '0;
                left_next = 1'b0;
                op_next   = bee_pkg::OP_NONE;
                neg_next  = 1'b0;
                pos_next  = '0;
            end
            else if (active && !emit)
            begin
                pos_next = pos_reg + PW'(1);
                case (mode_reg)
                    bee_pkg::MODE_TERM:
                    begin
                        if (char_code == bee_pkg::CH_NOT)
                            neg_next = !neg_reg;
                        else if (char_code == bee_pkg::CH_OPEN)
                        begin
                            wr_en     = (nest_reg != '0);
                            top_next  = '{negate: neg_reg, op: op_reg, left: left_reg};
                            nest_next = nest_reg + NW'(1);
                            left_next = 1'b0;
                            op_next   = bee_pkg::OP_NONE;
                            neg_next  = 1'b0;
                        end
                        else
                        begin
                            neg_next = 1'b0;
                            op_next  = bee_pkg::OP_NONE;
                            case (fin_op)
                                bee_pkg::OP_AND: left_next = fin_left & (fin_val ^ fin_neg);
                                bee_pkg::OP_OR:  left_next = fin_left | (fin_val ^ fin_neg);
                                default:         left_next = fin_val ^ fin_neg;
                            endcase
                        end
                    end
                    default:
                    begin
                        if (char_code == bee_pkg::CH_AND)
                            op_next = bee_pkg::OP_AND;
                        else if (char_code == bee_pkg::CH_OR)
                            op_next = bee_pkg::OP_OR;
                        else
                        begin
                            // close: pop the frame and finish the term
                            nest_next = nest_reg - NW'(1);
                            top_next  = below;
                            neg_next  = 1'b0;
                            op_next   = bee_pkg::OP_NONE;
                            case (fin_op)
                                bee_pkg::OP_AND: left_next = fin_left & (fin_val ^ fin_neg);
                                bee_pkg::OP_OR:  left_next = fin_left | (fin_val ^ fin_neg);
                                default:         left_next = fin_val ^ fin_neg;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    // read ahead the frame just below the next top
    assign rd_addr = AW'(nest_next - NW'(2));

    // frame memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= top_reg;
        mem_q_reg    <= frame_mem[rd_addr];
        fwd_data_reg <= top_reg;
    end

    // bypass flag for a read of the entry written in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= wr_en && (wr_addr == rd_addr);
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bee_pkg::MODE_TERM;
            nest_reg <= '0;
            left_reg <= 1'b0;
            op_reg   <= bee_pkg::OP_NONE;
            neg_reg  <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            nest_reg <= nest_next;
            left_reg <= left_next;
            op_reg   <= op_next;
            neg_reg  <= neg_next;
            pos_reg  <= pos_next;
        end
    end

    // innermost frame
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // output transaction control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            status_reg <= emit_status;
            truth_reg  <= (emit_status == bee_pkg::STATUS_OK) ? left_reg : 1'b0;
            errpos_reg <= (emit_status == bee_pkg::STATUS_OK) ? '0 : pos_sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign truth_value    = truth_reg;
    assign error_position = errpos_reg;

endmodule
